### rtl/aip_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types and constants of the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

	localparam int CHAR_W     = 8;
	localparam int VAL_W      = 64;
	localparam int CNT_W      = 8;
	localparam int DIG_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	// accumulator times base plus digit, before the range check
	localparam int SUM_W      = VAL_W + DIG_W;

	localparam logic [1:0] BM_AUTO = 2'd0;
	localparam logic [1:0] BM_DEC  = 2'd1;
	localparam logic [1:0] BM_HEX  = 2'd2;

	localparam logic [1:0] RW_8  = 2'd0;
	localparam logic [1:0] RW_16 = 2'd1;
	localparam logic [1:0] RW_32 = 2'd2;
	localparam logic [1:0] RW_64 = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NODIG = 2'd1;
	localparam logic [1:0] ST_OVF   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RESULT_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS   = 2'd2;

	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_LA   = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF   = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA   = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF   = 8'h46;
	localparam logic [CHAR_W-1:0] CH_X    = 8'h78;

	localparam logic [CNT_W-1:0] CNT_MAX    = 8'd255;
	localparam logic [CNT_W-1:0] PREFIX_LEN = 8'd2;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              start_req;
		logic              negate;
	} in_word_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [1:0]       status;
		logic [CNT_W-1:0] chars_used;
	} out_word_t;

	typedef struct packed {
		logic [1:0]       base_mode;
		logic [1:0]       result_width;
		logic [CNT_W-1:0] max_digits;
	} cfg_t;

	// classified character, front to back
	typedef struct packed {
		logic             start;
		logic             negate;
		logic             is_dec;
		logic             is_hex_letter;
		logic             is_x;
		logic             is_zero;
		logic [DIG_W-1:0] digit;
	} cls_t;

	// finished number before sign and width handling
	typedef struct packed {
		logic [VAL_W-1:0] acc;
		logic             neg;
		logic             ovf;
		logic             nodig;
		logic [CNT_W-1:0] ccnt;
	} raw_t;

	function automatic logic [VAL_W-1:0] width_mask(input logic [1:0] rw);
		logic [VAL_W-1:0] m;
		case (rw)
			RW_8:    m = 64'h0000_0000_0000_00FF;
			RW_16:   m = 64'h0000_0000_0000_FFFF;
			RW_32:   m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

### rtl/aip_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface aip_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/aip_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_front
// Accepts characters and classifies them into digit / prefix / other.
// ----------------------------------------------------------------------------
module aip_front import aip_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	aip_stream_if.sink   in,
	output cls_t         cls,
	output logic         cls_valid,
	input  logic         cls_ready
);

	logic valid_s1;
	cls_t cls_s1;
	cls_t cls_d;
	logic [CHAR_W-1:0] c;

	assign in.ready = !valid_s1 || cls_ready;

	always_comb begin
		c                 = in.data.character;
		cls_d.start       = in.data.start_req;
		cls_d.negate      = in.data.negate;
		cls_d.is_dec      = c inside {[CH_ZERO:CH_NINE]};
		cls_d.is_hex_letter = (c inside {[CH_LA:CH_LF]}) || (c inside {[CH_UA:CH_UF]});
		cls_d.is_x        = (c == CH_X);
		cls_d.is_zero     = (c == CH_ZERO);
		// low nibble is the value for '0'..'9'; letters sit at 1..6, so add nine
		if (cls_d.is_dec) begin
			cls_d.digit = c[DIG_W-1:0];
		end else begin
			cls_d.digit = c[DIG_W-1:0] + 4'd9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.ready) begin
			valid_s1 <= in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			cls_s1 <= cls_d;
		end
	end

	assign cls       = cls_s1;
	assign cls_valid = valid_s1;

endmodule
`default_nettype wire

### rtl/aip_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_queue
// Two-word queue between front and back.
// ----------------------------------------------------------------------------
module aip_queue import aip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_word,
	output logic can_push,
	output logic pop_valid,
	output cls_t pop_word,
	input  logic pop
);

	localparam int QDEPTH = 2;
	localparam int PTR_W  = $clog2(QDEPTH);
	localparam int CNT_QW = $clog2(QDEPTH + 1);

	cls_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_QW-1:0] count_q;

	assign pop_valid = (count_q != '0);
	assign can_push  = (count_q != CNT_QW'(QDEPTH)) || pop;
	assign pop_word  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/aip_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aip_back
// Number state machine and accumulator, then sign/width result stage.
// ----------------------------------------------------------------------------
module aip_back import aip_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         word_valid,
	input  cls_t         word,
	output logic         pop,
	aip_stream_if.source out
);

	// number state
	logic             act_q, hex_q, zpp_q, ovf_q, neg_q;
	logic [VAL_W-1:0] acc_q;
	logic [CNT_W-1:0] dcnt_q, ccnt_q;

	logic             n_act, n_hex, n_zpp, n_ovf, n_neg;
	logic [VAL_W-1:0] n_acc;
	logic [CNT_W-1:0] n_dcnt, n_ccnt;
	logic             may_prefix, emit, digit_ok, at_limit;
	logic [SUM_W-1:0] sum;
	logic [VAL_W-1:0] mask;

	logic      raw_valid_s1;
	raw_t      raw_s1;
	logic      s1_ready, out_load;
	logic      out_valid_q;
	out_word_t out_word_q;
	logic [VAL_W-1:0] signed_val;

	assign mask     = width_mask(cfg.result_width);
	assign out_load = !out_valid_q || out.ready;
	assign s1_ready = !raw_valid_s1 || out_load;
	assign pop      = word_valid && s1_ready;

	always_comb begin
		n_act      = act_q;
		n_acc      = acc_q;
		n_dcnt     = dcnt_q;
		n_ccnt     = ccnt_q;
		n_hex      = hex_q;
		n_zpp      = zpp_q;
		n_ovf      = ovf_q;
		n_neg      = neg_q;
		may_prefix = 1'b0;
		emit       = 1'b0;
		digit_ok   = 1'b0;
		at_limit   = 1'b0;
		sum        = '0;

		if (word.start) begin
			n_act      = 1'b1;
			n_acc      = '0;
			n_dcnt     = '0;
			n_ccnt     = '0;
			n_hex      = (cfg.base_mode == BM_HEX);
			n_zpp      = 1'b0;
			n_ovf      = 1'b0;
			n_neg      = word.negate;
			may_prefix = (cfg.base_mode == BM_AUTO);
		end

		if (n_act) begin
			if (n_zpp && word.is_x) begin
				// "0x" seen: restart as hex, prefix counts two chars
				n_zpp  = 1'b0;
				n_hex  = 1'b1;
				n_acc  = '0;
				n_dcnt = '0;
				n_ccnt = PREFIX_LEN;
			end else begin
				n_zpp    = 1'b0;
				digit_ok = word.is_dec || (n_hex && word.is_hex_letter);
				at_limit = (cfg.max_digits != '0) && (n_dcnt >= cfg.max_digits);
				if (!digit_ok || at_limit) begin
					emit = 1'b1;
				end else begin
					if (n_hex) begin
						sum = {n_acc, 4'b0000} + {{VAL_W{1'b0}}, word.digit};
					end else begin
						sum = {1'b0, n_acc, 3'b000} + {3'b000, n_acc, 1'b0}
							+ {{VAL_W{1'b0}}, word.digit};
					end
					if (!n_ovf) begin
						if (sum > {{DIG_W{1'b0}}, mask}) begin
							n_ovf = 1'b1;
						end else begin
							n_acc = sum[VAL_W-1:0];
						end
					end
					if (n_dcnt != CNT_MAX) begin
						n_dcnt = n_dcnt + 1'b1;
					end
					if (n_ccnt != CNT_MAX) begin
						n_ccnt = n_ccnt + 1'b1;
					end
					// a leading zero may still turn into a prefix; limit waits
					if (may_prefix && word.is_zero) begin
						n_zpp = 1'b1;
					end else if ((cfg.max_digits != '0) && (n_dcnt >= cfg.max_digits)) begin
						emit = 1'b1;
					end
				end
			end
			if (emit) begin
				n_act = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			acc_q  <= '0;
			dcnt_q <= '0;
			ccnt_q <= '0;
			hex_q  <= 1'b0;
			zpp_q  <= 1'b0;
			ovf_q  <= 1'b0;
			neg_q  <= 1'b0;
		end else if (pop) begin
			act_q  <= n_act;
			acc_q  <= n_acc;
			dcnt_q <= n_dcnt;
			ccnt_q <= n_ccnt;
			hex_q  <= n_hex;
			zpp_q  <= n_zpp;
			ovf_q  <= n_ovf;
			neg_q  <= n_neg;
		end
	end

	// raw result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			raw_valid_s1 <= pop && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			raw_s1.acc   <= n_acc;
			raw_s1.neg   <= n_neg;
			raw_s1.ovf   <= n_ovf;
			raw_s1.nodig <= (n_dcnt == '0);
			raw_s1.ccnt  <= n_ccnt;
		end
	end

	// output register: sign and width
	assign signed_val = raw_s1.neg ? (~raw_s1.acc + 1'b1) : raw_s1.acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= raw_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && raw_valid_s1) begin
			out_word_q.chars_used <= raw_s1.ccnt;
			if (raw_s1.ovf) begin
				out_word_q.value  <= '0;
				out_word_q.status <= ST_OVF;
			end else if (raw_s1.nodig) begin
				out_word_q.value  <= '0;
				out_word_q.status <= ST_NODIG;
			end else begin
				out_word_q.value  <= signed_val & mask;
				out_word_q.status <= ST_OK;
			end
		end
	end

	assign out.valid = out_valid_q;
	assign out.data  = out_word_q;

endmodule
`default_nettype wire

### rtl/ascii_integer_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streaming ASCII to integer parser with optional negate, decimal / hex / auto "0x".
// ----------------------------------------------------------------------------
// Usage:
//   in  : one character per word (character, start_req, negate). start_req
//         opens a new number; characters with no open number are dropped.
//   out : one word per finished number (value, status, chars_used). A number
//         ends on the digit that reaches max_digits or on the first non-digit,
//         which is not counted.
//   cfg : cfg_we/cfg_index/cfg_wdata write base_mode, result_width and
//         max_digits; write them only while no number is in flight.
// Throughput is one character per cycle while out is not stalled; the accumulate
// step (base times accumulator plus digit with range check) is combinational.
// An accepted character passes the front register, queue, accumulator and raw
// result stage, and result register before its result word appears.
// After reset no number is open, base_mode is automatic, result_width is
// four bytes and max_digits is unlimited.
// When out is stalled the result register holds; the queue and front keep
// taking characters until the two-word queue and stages fill, then in.ready
// drops.
// ----------------------------------------------------------------------------
module ascii_integer_parser import aip_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	aip_stream_if.sink            in,
	aip_stream_if.source          out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t cfg_q;
	cls_t front_word, queue_word;
	logic front_valid, front_ready, queue_valid, queue_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_mode    <= BM_AUTO;
			cfg_q.result_width <= RW_32;
			cfg_q.max_digits   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE_MODE:    cfg_q.base_mode    <= cfg_wdata[1:0];
				CFG_RESULT_WIDTH: cfg_q.result_width <= cfg_wdata[1:0];
				CFG_MAX_DIGITS:   cfg_q.max_digits   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	aip_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.cls       (front_word),
		.cls_valid (front_valid),
		.cls_ready (front_ready)
	);

	aip_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid && front_ready),
		.push_word (front_word),
		.can_push  (front_ready),
		.pop_valid (queue_valid),
		.pop_word  (queue_word),
		.pop       (queue_pop)
	);

	aip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.word_valid (queue_valid),
		.word       (queue_word),
		.pop        (queue_pop),
		.out        (out)
	);

`ifndef SYNTHESIS
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && (out.data.status != ST_OK) |-> out.data.value == '0)
		else $error("non-ok result with nonzero value");

	a_nodig_count: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && (out.data.status == ST_NODIG) |->
			(out.data.chars_used == '0) || (out.data.chars_used == PREFIX_LEN))
		else $error("no-digit result with unexpected char count");

	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && (out.data.status == ST_OK) |-> out.data.chars_used != '0)
		else $error("ok result with zero chars used");
`endif

endmodule
`default_nettype wire
